// ===== hw/rtl/lpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lpp_pkg: shared types and constants of the LiDAR point prefilter.
// No dependencies; imported by every lpp_* module and the core.
package lpp_pkg;

    localparam int COORD_W        = 32;   // coordinate port width
    localparam int COORD_BITS_DEF = 32;   // default used coordinate bits
    localparam int REFL_W         = 16;
    localparam int TIME_W         = 32;
    localparam int TIME_US_W      = 64;
    localparam int RSQ_W          = 64;
    localparam int LINE_W         = 8;
    localparam int TAG_W          = 8;
    localparam int CNT_W          = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIND_SQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EVERY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 3'd4;

    // modes
    localparam logic [1:0] MODE_TAGGED = 2'd0;
    localparam logic [1:0] MODE_INCL   = 2'd1;
    localparam logic [1:0] MODE_ZERO_T = 2'd3;

    // time units
    localparam logic [1:0] UNIT_S  = 2'd0;
    localparam logic [1:0] UNIT_MS = 2'd1;
    localparam logic [1:0] UNIT_US = 2'd2;
    localparam logic [1:0] UNIT_NS = 2'd3;

    // time multiplier; ns uses floor(t * ceil(2^38/1000) / 2^38), exact for 32-bit t
    localparam int TMUL_W = 29;
    localparam int TPROD_W = TIME_W + TMUL_W;
    localparam logic [TMUL_W-1:0] TMUL_S     = 29'd1000000;
    localparam logic [TMUL_W-1:0] TMUL_MS    = 29'd1000;
    localparam logic [TMUL_W-1:0] TMUL_US    = 29'd1;
    localparam logic [TMUL_W-1:0] TMUL_NS    = 29'd274877907;
    localparam int                NS_SHIFT   = 38;

    localparam int TAG_BAD_BIT = 5;

    // register reset values
    localparam logic [1:0]        RST_MODE       = 2'd0;
    localparam logic [RSQ_W-1:0]  RST_BLIND_SQ   = 64'd429497;
    localparam logic [CNT_W-1:0]  RST_KEEP_EVERY = 8'd1;
    localparam logic [LINE_W-1:0] RST_SCAN_LINES = 8'd6;
    localparam logic [1:0]        RST_TIME_SCALE = 2'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [RSQ_W-1:0]  blind_sq;
        logic [CNT_W-1:0]  keep_every;
        logic [LINE_W-1:0] scan_lines;
        logic [1:0]        time_scale;
    } t_cfg;

endpackage
`default_nettype wire

// ===== hw/rtl/lidar_point_prefilter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lidar_point_prefilter_core: top level of the LiDAR point prefilter.
// Depends on lpp_pkg, lpp_cfg, lpp_sel, lpp_range_pipe.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready    | frame_start, pos_x/y/z, reflect, time,
//          |                            | laser_line, point_tag
//  out     | o_out_valid / i_out_ready  | out_x/y/z, out_reflect, time_us
//  cfg     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One word accepted per cycle while o_in_ready is high. A kept word passes the
// input register, multiplier stage and range-sum stage, then the blind test
// into the output register. Dropped words leave no result.
// Reset (synchronous, active low) clears the pipeline, decimation counter and
// previous-point slot and loads register defaults. When the output stalls the
// pipeline fills and o_in_ready falls after its four stages are occupied.
module lidar_point_prefilter_core
    import lpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_frame_start,
    input  wire logic signed [COORD_W-1:0] i_pos_x,
    input  wire logic signed [COORD_W-1:0] i_pos_y,
    input  wire logic signed [COORD_W-1:0] i_pos_z,
    input  wire logic [REFL_W-1:0]     i_reflect,
    input  wire logic [TIME_W-1:0]     i_time_offset,
    input  wire logic [LINE_W-1:0]     i_laser_line,
    input  wire logic [TAG_W-1:0]      i_point_tag,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [COORD_W-1:0]  o_out_x,
    output logic signed [COORD_W-1:0]  o_out_y,
    output logic signed [COORD_W-1:0]  o_out_z,
    output logic [REFL_W-1:0]          o_out_reflect,
    output logic [TIME_US_W-1:0]       o_time_us
);

    t_cfg cfg;
    logic acc;
    logic keep;
    logic signed [COORD_BITS-1:0] x, y, z;

    // only the low COORD_BITS of each coordinate are used, sign-extended
    assign x   = i_pos_x[COORD_BITS-1:0];
    assign y   = i_pos_y[COORD_BITS-1:0];
    assign z   = i_pos_z[COORD_BITS-1:0];
    assign acc = i_in_valid && o_in_ready;

    lpp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpp_sel #(
        .COORD_BITS (COORD_BITS)
    ) u_sel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_cfg         (cfg),
        .i_frame_start (i_frame_start),
        .i_x           (x),
        .i_y           (y),
        .i_z           (z),
        .i_line        (i_laser_line),
        .i_tag         (i_point_tag),
        .o_keep        (keep)
    );

    lpp_range_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_load    (acc && keep),
        .i_x       (x),
        .i_y       (y),
        .i_z       (z),
        .i_refl    (i_reflect),
        .i_time    (i_time_offset),
        .o_ready   (o_in_ready),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_x       (o_out_x),
        .o_y       (o_out_y),
        .o_z       (o_out_z),
        .o_refl    (o_out_reflect),
        .o_time_us (o_time_us)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lpp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lpp_cfg: configuration register file of the prefilter.
// Depends on lpp_pkg.
module lpp_cfg
    import lpp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= RST_MODE;
            r_cfg.blind_sq   <= RST_BLIND_SQ;
            r_cfg.keep_every <= RST_KEEP_EVERY;
            r_cfg.scan_lines <= RST_SCAN_LINES;
            r_cfg.time_scale <= RST_TIME_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:       r_cfg.mode       <= i_cfg_data[1:0];
                CFG_BLIND_SQ:   r_cfg.blind_sq   <= i_cfg_data[RSQ_W-1:0];
                CFG_KEEP_EVERY: r_cfg.keep_every <= i_cfg_data[CNT_W-1:0];
                CFG_SCAN_LINES: r_cfg.scan_lines <= i_cfg_data[LINE_W-1:0];
                CFG_TIME_SCALE: r_cfg.time_scale <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== hw/rtl/lpp_sel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lpp_sel: frame state, decimation counter, previous-point slot and the
// per-word pass decision taken at input acceptance. Depends on lpp_pkg.
module lpp_sel
    import lpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_acc,
    input  wire t_cfg                         i_cfg,
    input  wire logic                         i_frame_start,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic signed [COORD_BITS-1:0] i_z,
    input  wire logic [LINE_W-1:0]            i_line,
    input  wire logic [TAG_W-1:0]             i_tag,
    output logic                              o_keep
);

    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic signed [COORD_BITS-1:0] n_px, n_py, n_pz;

    logic [CNT_W-1:0]            cnt_base;
    logic signed [COORD_BITS-1:0] px_base, py_base, pz_base;
    logic [CNT_W-1:0]            keep_n;
    logic [CNT_W:0]              cnt_inc;
    logic                        wrap;
    logic                        line_ok;
    logic                        pass;
    logic                        differs;

    always_comb begin
        // frame start clears counter and slot before this word is judged
        cnt_base = i_frame_start ? '0 : r_cnt;
        px_base  = i_frame_start ? '0 : r_px;
        py_base  = i_frame_start ? '0 : r_py;
        pz_base  = i_frame_start ? '0 : r_pz;
        keep_n   = (i_cfg.keep_every == '0) ? CNT_W'(1) : i_cfg.keep_every;
        cnt_inc  = {1'b0, cnt_base} + (CNT_W+1)'(1);
        wrap     = cnt_inc >= {1'b0, keep_n};
        differs  = (i_x != px_base) || (i_y != py_base) || (i_z != pz_base);
        line_ok  = !i_frame_start && (i_line < i_cfg.scan_lines) && !i_tag[TAG_BAD_BIT];
        n_px     = '0;
        n_py     = '0;
        n_pz     = '0;
        if (i_cfg.mode == MODE_TAGGED) begin
            pass  = line_ok && wrap;
            n_cnt = !line_ok ? cnt_base : (wrap ? '0 : cnt_inc[CNT_W-1:0]);
            if (pass) begin
                n_px = i_x;
                n_py = i_y;
                n_pz = i_z;
            end
            o_keep = pass && differs;
        end else begin
            pass   = (cnt_base == '0);
            n_cnt  = wrap ? '0 : cnt_inc[CNT_W-1:0];
            o_keep = pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_px  <= '0;
            r_py  <= '0;
            r_pz  <= '0;
        end else if (i_acc) begin
            r_cnt <= n_cnt;
            r_px  <= n_px;
            r_py  <= n_py;
            r_pz  <= n_pz;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lpp_range_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lpp_range_pipe: squared-range and time-conversion pipeline, blind test and
// output register for kept words. Depends on lpp_pkg.
module lpp_range_pipe
    import lpp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cfg                         i_cfg,
    input  wire logic                         i_load,
    input  wire logic signed [COORD_BITS-1:0] i_x,
    input  wire logic signed [COORD_BITS-1:0] i_y,
    input  wire logic signed [COORD_BITS-1:0] i_z,
    input  wire logic [REFL_W-1:0]            i_refl,
    input  wire logic [TIME_W-1:0]            i_time,
    output logic                              o_ready,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [COORD_W-1:0]         o_x,
    output logic signed [COORD_W-1:0]         o_y,
    output logic signed [COORD_W-1:0]         o_z,
    output logic [REFL_W-1:0]                 o_refl,
    output logic [TIME_US_W-1:0]              o_time_us
);

    localparam int SQ_W = 2 * COORD_BITS;

    // stage 1: captured word plus coordinate magnitudes
    logic                          r1_v;
    logic signed [COORD_BITS-1:0]  r1_x, r1_y, r1_z;
    logic [COORD_BITS-1:0]         r1_mx, r1_my, r1_mz;
    logic [REFL_W-1:0]             r1_refl;
    logic [TIME_W-1:0]             r1_t;
    // stage 2: squares and time product
    logic                          r2_v;
    logic signed [COORD_BITS-1:0]  r2_x, r2_y, r2_z;
    logic [SQ_W-1:0]               r2_sx, r2_sy, r2_sz;
    logic [REFL_W-1:0]             r2_refl;
    logic [TPROD_W-1:0]            r2_prod;
    // stage 3: squared range and final time
    logic                          r3_v;
    logic signed [COORD_BITS-1:0]  r3_x, r3_y, r3_z;
    logic [RSQ_W-1:0]              r3_rsq;
    logic [REFL_W-1:0]             r3_refl;
    logic [TIME_US_W-1:0]          r3_tus;
    // output register
    logic                          r_ov;
    logic signed [COORD_W-1:0]     r_ox, r_oy, r_oz;
    logic [REFL_W-1:0]             r_orefl;
    logic [TIME_US_W-1:0]          r_otus;

    logic en1, en2, en3, en_out;
    logic [TMUL_W-1:0]    tmul;
    logic [TIME_US_W-1:0] n_tus;
    logic                 beyond;

    assign en_out  = !r_ov || i_ready;
    assign en3     = !r3_v || en_out;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    always_comb begin
        case (i_cfg.time_scale)
            UNIT_S:  tmul = TMUL_S;
            UNIT_MS: tmul = TMUL_MS;
            UNIT_US: tmul = TMUL_US;
            UNIT_NS: tmul = TMUL_NS;
            default: tmul = TMUL_US;
        endcase
        if (i_cfg.mode == MODE_ZERO_T) begin
            n_tus = '0;
        end else if (i_cfg.time_scale == UNIT_NS) begin
            n_tus = TIME_US_W'(r2_prod >> NS_SHIFT);
        end else begin
            n_tus = TIME_US_W'(r2_prod);
        end
        // inclusive mode also keeps a point lying exactly on the radius
        beyond = (r3_rsq > i_cfg.blind_sq) ||
                 ((i_cfg.mode == MODE_INCL) && (r3_rsq == i_cfg.blind_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_load;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
            if (en_out) begin
                r_ov <= r3_v && beyond;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x    <= i_x;
            r1_y    <= i_y;
            r1_z    <= i_z;
            r1_mx   <= i_x[COORD_BITS-1] ? COORD_BITS'(-i_x) : COORD_BITS'(i_x);
            r1_my   <= i_y[COORD_BITS-1] ? COORD_BITS'(-i_y) : COORD_BITS'(i_y);
            r1_mz   <= i_z[COORD_BITS-1] ? COORD_BITS'(-i_z) : COORD_BITS'(i_z);
            r1_refl <= i_refl;
            r1_t    <= i_time;
        end
        if (en2) begin
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_sx   <= SQ_W'(r1_mx) * SQ_W'(r1_mx);
            r2_sy   <= SQ_W'(r1_my) * SQ_W'(r1_my);
            r2_sz   <= SQ_W'(r1_mz) * SQ_W'(r1_mz);
            r2_refl <= r1_refl;
            r2_prod <= TPROD_W'(r1_t) * TPROD_W'(tmul);
        end
        if (en3) begin
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_z    <= r2_z;
            // sum wraps at 64 bits
            r3_rsq  <= RSQ_W'(r2_sx) + RSQ_W'(r2_sy) + RSQ_W'(r2_sz);
            r3_refl <= r2_refl;
            r3_tus  <= n_tus;
        end
        if (en_out) begin
            r_ox    <= COORD_W'(r3_x);
            r_oy    <= COORD_W'(r3_y);
            r_oz    <= COORD_W'(r3_z);
            r_orefl <= r3_refl;
            r_otus  <= r3_tus;
        end
    end

    assign o_valid   = r_ov;
    assign o_x       = r_ox;
    assign o_y       = r_oy;
    assign o_z       = r_oz;
    assign o_refl    = r_orefl;
    assign o_time_us = r_otus;

endmodule
`default_nettype wire

// ===== test/lidar_point_prefilter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lidar_point_prefilter_core: queued point words feed a
// valid/ready driver, a predictor tracks decimation and the duplicate slot.
// Depends on lpp_pkg and the core RTL only.
module lidar_point_prefilter_core_tb
    import lpp_pkg::*;
();

    localparam logic [1:0] MODE_PLAIN  = 2'd2;   // no name in the package
    localparam int         MAX_SHOWN   = 10;
    localparam int         DRAIN_WAIT  = 8;      // pipeline is four stages deep
    localparam int         LONG_HOLD   = 80;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         N_PHASES    = 16;
    localparam int         PHASE_PTS   = 24;

    typedef struct {
        logic                      frame_start;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [REFL_W-1:0]         reflect;
        logic [TIME_W-1:0]         time_offset;
        logic [LINE_W-1:0]         line;
        logic [TAG_W-1:0]          tag;
    } t_point;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [REFL_W-1:0]         reflect;
        logic [TIME_US_W-1:0]      time_us;
    } t_kept;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_frame_start = 1'b0;
    logic signed [COORD_W-1:0]    i_pos_x = '0;
    logic signed [COORD_W-1:0]    i_pos_y = '0;
    logic signed [COORD_W-1:0]    i_pos_z = '0;
    logic [REFL_W-1:0]            i_reflect = '0;
    logic [TIME_W-1:0]            i_time_offset = '0;
    logic [LINE_W-1:0]            i_laser_line = '0;
    logic [TAG_W-1:0]             i_point_tag = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [COORD_W-1:0]    o_out_x;
    logic signed [COORD_W-1:0]    o_out_y;
    logic signed [COORD_W-1:0]    o_out_z;
    logic [REFL_W-1:0]            o_out_reflect;
    logic [TIME_US_W-1:0]         o_time_us;

    lidar_point_prefilter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_frame_start (i_frame_start),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_reflect     (i_reflect),
        .i_time_offset (i_time_offset),
        .i_laser_line  (i_laser_line),
        .i_point_tag   (i_point_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_out_reflect (o_out_reflect),
        .o_time_us     (o_time_us)
    );

    // predictor state and register shadow
    t_cfg                      cfg;
    logic [CNT_W-1:0]          decim_cnt;
    logic signed [COORD_W-1:0] slot_x, slot_y, slot_z;

    t_point pts_q[$];
    t_kept  kept_q[$];
    t_point bus_pt;
    t_point last_pt;
    t_kept  got_want;
    t_kept  new_kept;

    int  frame_left = 0;
    int  src_idle_max = 10;
    int  snk_idle_max = 10;
    int  src_gap = 0;
    int  snk_wait = 0;
    int  hold_left = 0;
    bit  hold_go = 1'b0;
    bit  hold_started = 1'b0;
    bit  pt_pending = 1'b0;
    bit  pt_taken = 1'b0;
    bit  out_taken = 1'b0;
    bit  rdy;
    int  cyc = 0;
    int  n_fail = 0;
    int  n_pts = 0;
    int  n_kept = 0;
    int  n_phase = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [RSQ_W-1:0] coord_sq(input logic signed [COORD_W-1:0] c);
        longint v;
        v = c;
        if (v < 0) v = -v;
        return v * v;
    endfunction

    // One point through the filter; returns 1 with the kept word when it survives.
    function automatic bit prefilter_step(input t_point p, output t_kept k);
        logic [RSQ_W-1:0] rsq;
        logic [CNT_W:0]   cnt_nx;
        logic [CNT_W-1:0] keep_n;
        bit               pass;
        bit               keep;
        keep_n = (cfg.keep_every == '0) ? CNT_W'(1) : cfg.keep_every;
        rsq = coord_sq(p.x) + coord_sq(p.y) + coord_sq(p.z);
        keep = 1'b0;
        pass = 1'b0;
        if (p.frame_start) begin
            decim_cnt = '0;
            {slot_x, slot_y, slot_z} = '0;
        end
        if (cfg.mode == MODE_TAGGED) begin
            if (!p.frame_start && p.line < cfg.scan_lines && !p.tag[TAG_BAD_BIT]) begin
                cnt_nx = {1'b0, decim_cnt} + (CNT_W+1)'(1);
                if (cnt_nx >= keep_n) begin
                    cnt_nx = '0;
                    pass = 1'b1;
                end
                decim_cnt = cnt_nx[CNT_W-1:0];
            end
            if (pass) begin
                keep = (p.x != slot_x || p.y != slot_y || p.z != slot_z) &&
                       rsq > cfg.blind_sq;
                slot_x = p.x;
                slot_y = p.y;
                slot_z = p.z;
            end else begin
                {slot_x, slot_y, slot_z} = '0;
            end
        end else begin
            pass = (decim_cnt == '0);
            cnt_nx = {1'b0, decim_cnt} + (CNT_W+1)'(1);
            decim_cnt = (cnt_nx >= keep_n) ? '0 : cnt_nx[CNT_W-1:0];
            {slot_x, slot_y, slot_z} = '0;
            if (pass)
                keep = (cfg.mode == MODE_INCL) ? rsq >= cfg.blind_sq : rsq > cfg.blind_sq;
        end
        k.x = p.x;
        k.y = p.y;
        k.z = p.z;
        k.reflect = p.reflect;
        case (cfg.time_scale)
            UNIT_S:  k.time_us = p.time_offset * 64'd1000000;
            UNIT_MS: k.time_us = p.time_offset * 64'd1000;
            UNIT_US: k.time_us = p.time_offset;
            default: k.time_us = p.time_offset / 64'd1000;
        endcase
        if (cfg.mode == MODE_ZERO_T) k.time_us = '0;
        return keep;
    endfunction

    function automatic t_point pt(input bit fs, input int x, input int y, input int z,
                                  input int refl, input int t, input int line,
                                  input int tag);
        t_point p;
        p.frame_start = fs;
        p.x = x;
        p.y = y;
        p.z = z;
        p.reflect = REFL_W'(refl);
        p.time_offset = t;
        p.line = LINE_W'(line);
        p.tag = TAG_W'(tag);
        return p;
    endfunction

    // Mostly well-formed frames; some repeats, one-LSB neighbors, near-blind and
    // full-range coordinates, and a share of bad lines and tags.
    function automatic t_point rand_pt();
        t_point p;
        int     sel;
        p.frame_start = (frame_left == 0);
        if (p.frame_start) frame_left = $urandom_range(1, 30);
        frame_left--;
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
            p.x = last_pt.x;
            p.y = last_pt.y;
            p.z = last_pt.z;
            if (sel >= 12) begin
                case ($urandom_range(0, 2))
                    0:       p.x = p.x + 1;
                    1:       p.y = p.y + 1;
                    default: p.z = p.z + 1;
                endcase
            end
        end else if (sel < 32) begin
            p.x = $urandom_range(0, 2000) - 1000;
            p.y = $urandom_range(0, 2000) - 1000;
            p.z = $urandom_range(0, 2000) - 1000;
        end else if (sel < 47) begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end else begin
            p.x = $urandom_range(0, 1 << 23) - (1 << 22);
            p.y = $urandom_range(0, 1 << 23) - (1 << 22);
            p.z = $urandom_range(0, 1 << 23) - (1 << 22);
        end
        p.reflect = REFL_W'($urandom);
        p.time_offset = $urandom;
        if ($urandom_range(0, 99) < 85 && cfg.scan_lines != 0)
            p.line = LINE_W'($urandom_range(0, cfg.scan_lines - 1));
        else
            p.line = LINE_W'($urandom_range(0, 255));
        p.tag = TAG_W'($urandom);
        if ($urandom_range(0, 99) < 85) p.tag[TAG_BAD_BIT] = 1'b0;
        last_pt = p;
        return p;
    endfunction

    task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
        n_fail++;
        if (n_fail <= MAX_SHOWN)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:       cfg.mode       = data[1:0];
            CFG_BLIND_SQ:   cfg.blind_sq   = data;
            CFG_KEEP_EVERY: cfg.keep_every = data[CNT_W-1:0];
            CFG_SCAN_LINES: cfg.scan_lines = data[LINE_W-1:0];
            CFG_TIME_SCALE: cfg.time_scale = data[1:0];
            default: ;
        endcase
    endtask

    task automatic add_pt(input t_point p);
        pts_q.insert(pts_q.size(), p);
    endtask

    // block idle: nothing queued, nothing on the bus, nothing outstanding
    task automatic drain();
        while (pts_q.size() != 0 || i_in_valid || kept_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Upper data bits are junk on purpose; a spare index write must be ignored.
    task automatic set_phase(input logic [1:0] mode, input logic [RSQ_W-1:0] blind,
                             input logic [CNT_W-1:0] keep, input logic [LINE_W-1:0] lines,
                             input logic [1:0] unit);
        logic [CFG_DATA_W-1:0] d;
        drain();
        d = {$urandom, $urandom};
        d[1:0] = mode;
        write_reg(CFG_MODE, d);
        write_reg(CFG_BLIND_SQ, blind);
        d = {$urandom, $urandom};
        d[CNT_W-1:0] = keep;
        write_reg(CFG_KEEP_EVERY, d);
        d = {$urandom, $urandom};
        d[LINE_W-1:0] = lines;
        write_reg(CFG_SCAN_LINES, d);
        d = {$urandom, $urandom};
        d[1:0] = unit;
        write_reg(CFG_TIME_SCALE, d);
        write_reg(CFG_IDX_W'($urandom_range(CFG_TIME_SCALE + 1, (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
        n_phase++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pt_taken) begin
                pt_pending = 1'b0;
                src_gap = $urandom_range(0, src_idle_max);
            end
            if (!pt_pending && pts_q.size() != 0) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else begin
                    bus_pt = pts_q.pop_front();
                    pt_pending = 1'b1;
                    i_frame_start <= bus_pt.frame_start;
                    i_pos_x       <= bus_pt.x;
                    i_pos_y       <= bus_pt.y;
                    i_pos_z       <= bus_pt.z;
                    i_reflect     <= bus_pt.reflect;
                    i_time_offset <= bus_pt.time_offset;
                    i_laser_line  <= bus_pt.line;
                    i_point_tag   <= bus_pt.tag;
                end
            end
            i_in_valid <= pt_pending;
        end
    end

    // output ready with per-word stalls and one long hold-off
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) snk_wait = $urandom_range(0, snk_idle_max);
            if (hold_go && !hold_started) begin
                hold_started = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_out_ready <= rdy;
        end
    end

    // monitor: predicts on input accept, checks on output accept
    always @(posedge i_clk) begin
        cyc++;
        pt_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_kept++;
            if (kept_q.size() == 0) begin
                flag("unexpected word, x", '0, o_out_x);
            end else begin
                got_want = kept_q.pop_front();
                if (o_out_x !== got_want.x) flag("x", got_want.x, o_out_x);
                if (o_out_y !== got_want.y) flag("y", got_want.y, o_out_y);
                if (o_out_z !== got_want.z) flag("z", got_want.z, o_out_z);
                if (o_out_reflect !== got_want.reflect)
                    flag("reflect", got_want.reflect, o_out_reflect);
                if (o_time_us !== got_want.time_us)
                    flag("time_us", got_want.time_us, o_time_us);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            n_pts++;
            if (prefilter_step(bus_pt, new_kept)) kept_q.insert(kept_q.size(), new_kept);
        end
    end

    initial begin
        while (cyc < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d words still expected", cyc, kept_q.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [CNT_W-1:0]  keep_tab [N_PHASES];
        logic [LINE_W-1:0] lines_tab [N_PHASES];
        logic [RSQ_W-1:0]  blind;
        cfg.mode       = RST_MODE;
        cfg.blind_sq   = RST_BLIND_SQ;
        cfg.keep_every = RST_KEEP_EVERY;
        cfg.scan_lines = RST_SCAN_LINES;
        cfg.time_scale = RST_TIME_SCALE;
        decim_cnt = '0;
        {slot_x, slot_y, slot_z} = '0;
        last_pt = pt(0, 0, 0, 0, 0, 0, 0, 0);
        keep_tab  = '{1, 8, 2, 0, 1, 3, 1, 255, 2, 1, 5, 1, 1, 4, 2, 1};
        lines_tab = '{128, 6, 6, 6, 0, 6, 6, 6, 1, 6, 6, 6, 255, 6, 6, 6};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tagged mode at reset settings: first-of-frame, duplicate, line, tag, blind
        src_idle_max = 0;
        add_pt(pt(1, 2000, 3000, 4000, 16'h1234, 5, 0, 0));
        add_pt(pt(0, 2000, 3000, 4000, 16'h1111, 6, 1, 0));
        add_pt(pt(0, 2000, 3000, 4000, 16'h2222, 7, 1, 0));
        add_pt(pt(0, 2000, 3000, 4001, 16'h3333, 8, 1, 0));
        add_pt(pt(0, 9000, 0, 0, 1, 9, 6, 0));
        add_pt(pt(0, 0, 0, 0, 2, 10, 2, 0));
        add_pt(pt(0, 9000, 1, 1, 3, 11, 3, 8'h20));
        add_pt(pt(0, 9000, 1, 1, 4, 12, 3, 8'h10));
        add_pt(pt(0, 9000, 1, 2, 5, 13, 4, 8'h30));
        add_pt(pt(0, 100, 100, 100, 6, 14, 0, 0));
        add_pt(pt(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff,
                  32'hffffffff, 5, 8'hcf));
        add_pt(pt(0, 32'h7fffffff, 32'h80000000, 1, 0, 0, 5, 8'hdf));

        // inclusive radius: a point exactly on it is kept
        set_phase(MODE_INCL, 64'd1000000, 1, 6, UNIT_S);
        add_pt(pt(1, 1000, 0, 0, 7, 32'hffffffff, 0, 0));
        add_pt(pt(0, 0, 600, 800, 8, 7, 0, 0));
        add_pt(pt(0, 999, 0, 0, 9, 7, 0, 0));

        // strict radius, ns truncation
        set_phase(MODE_PLAIN, 64'd1000000, 1, 6, UNIT_NS);
        add_pt(pt(1, 1000, 0, 0, 10, 5000, 0, 0));
        add_pt(pt(0, 1001, 0, 0, 11, 32'hffffffff, 0, 0));
        add_pt(pt(0, 0, 0, -1001, 12, 999, 0, 0));

        // zero-time mode, zero radius
        set_phase(MODE_ZERO_T, '0, 1, 6, UNIT_US);
        add_pt(pt(1, 0, 0, 0, 13, 12345, 0, 0));
        add_pt(pt(0, 1, 0, 0, 14, 12345, 0, 0));

        // random phases; frames run across phases so the counter goes stale
        for (int k = 0; k < N_PHASES; k++) begin
            case (k % 5)
                0:       blind = RST_BLIND_SQ;
                1:       blind = '0;
                2:       blind = $urandom_range(0, 1 << 22);
                3:       blind = '1;
                default: blind = 64'd1 << 44;
            endcase
            set_phase(2'(k % 4), blind, keep_tab[k], lines_tab[k], 2'((k + k / 4) % 4));
            src_idle_max = (k % 3 == 1) ? 0 : 10;
            snk_idle_max = (k % 3 == 2) ? 0 : 10;
            if (k == 5) begin
                // output held off while the source streams: pipeline fills, input stalls
                src_idle_max = 0;
                hold_go = 1'b1;
            end
            for (int i = 0; i < PHASE_PTS; i++)
                add_pt(rand_pt());
        end

        drain();
        while (kept_q.size() != 0) begin
            got_want = kept_q.pop_front();
            flag("missing word, x", got_want.x, '0);
        end
        $display("%0d points over %0d register settings, %0d kept words checked",
                 n_pts, n_phase, n_kept);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lpp_pkg.sv
hw/rtl/lpp_cfg.sv
hw/rtl/lpp_sel.sv
hw/rtl/lpp_range_pipe.sv
hw/rtl/lidar_point_prefilter_core.sv
test/lidar_point_prefilter_core_tb.sv
